>>> design/tssom_pkg.sv
// Shared types, constants and arithmetic helpers for the 2x2 shape-size-orientation metric.
package tssom_pkg;

  // Q16.16 data width and derived widths.
  localparam int unsigned DataW  = 32;
  localparam int unsigned DetW   = 64;
  localparam int unsigned DivW   = 128;
  localparam int unsigned QuotW  = 64;
  localparam int unsigned DivSteps = 64;
  localparam int unsigned BitsPerStage = 4;
  localparam int unsigned DivStages = DivSteps / BitsPerStage;
  localparam int unsigned OutTdataW = 256;

  localparam logic signed [DataW-1:0] QOne = 32'sh0001_0000;
  localparam logic signed [DataW-1:0] S32Max = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] S32Min = 32'sh8000_0000;

  typedef logic signed [DataW-1:0] q16_t;

  // Divider lane state: one inverse entry in progress.
  typedef struct packed {
    logic              neg;
    logic              zero;
    logic [DivW-1:0]   rem;
    logic [QuotW-1:0]  quo;
  } div_lane_t;

  // Q32.32 product to Q16.16, ties toward plus infinity (arithmetic shift is floor).
  function automatic logic signed [47:0] rnd16(input logic signed [63:0] p);
    logic signed [63:0] q;
    q = p + 64'sd32768;
    return q[63:16];
  endfunction

  // Saturate a wide signed value to signed 32 bits.
  function automatic q16_t sat32(input logic signed [50:0] v);
    if (v > 51'(S32Max)) begin
      return S32Max;
    end else if (v < 51'(S32Min)) begin
      return S32Min;
    end
    return v[DataW-1:0];
  endfunction

endpackage

>>> design/tssom_inv.sv
// Pipelined inversion of the target matrix: determinant, then a restoring divider per entry.
module tssom_inv (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  tssom_pkg::q16_t      a_i [4],
  input  tssom_pkg::q16_t      w_i [4],
  output logic                 valid_o,
  output tssom_pkg::q16_t      a_o [4],
  output tssom_pkg::q16_t      inv_o [4],
  output logic                 singular_o
);
  import tssom_pkg::*;

  // Stage 1 registers: products of the determinant.
  logic               v1_q;
  logic signed [63:0] p0_q, p1_q;
  q16_t               a1_q [4];
  q16_t               w1_q [4];

  // Stage 2 registers: determinant and divider setup.
  logic               v2_q;
  logic signed [63:0] det_q;
  q16_t               a2_q [4];
  q16_t               w2_q [4];

  // Divider pipeline registers.
  logic               vd_q   [DivStages+1];
  logic               sing_q [DivStages+1];
  logic [DetW-1:0]    nd_q   [DivStages+1];
  q16_t               ad_q   [DivStages+1][4];
  div_lane_t          ln_q   [DivStages+1][4];

  // Output stage registers.
  logic               vo_q;
  logic               so_q;
  q16_t               ao_q [4];
  q16_t               io_q [4];

  // Determinant products.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q  <= 64'(w_i[0]) * 64'(w_i[3]);
      p1_q  <= 64'(w_i[1]) * 64'(w_i[2]);
      a1_q  <= a_i;
      w1_q  <= w_i;
      det_q <= p0_q - p1_q;
      a2_q  <= a1_q;
      w2_q  <= w1_q;
    end
  end

  // Divider setup: magnitudes and signs of the adjugate entries and determinant.
  always_comb begin
    logic signed [32:0] adj [4];
    logic [32:0]        mag;
    logic               dneg;
    adj[0] = 33'(w2_q[3]);
    adj[1] = -33'(w2_q[1]);
    adj[2] = -33'(w2_q[2]);
    adj[3] = 33'(w2_q[0]);
    dneg = det_q[63];
    nd_q[0] = dneg ? (64'd0 - det_q) : det_q;
    vd_q[0] = v2_q;
    sing_q[0] = (det_q == 64'sd0);
    ad_q[0] = a2_q;
    for (int k = 0; k < 4; k++) begin
      mag = adj[k][32] ? (33'd0 - adj[k]) : adj[k];
      ln_q[0][k].neg  = adj[k][32] ^ dneg;
      ln_q[0][k].zero = (adj[k] == 33'sd0);
      ln_q[0][k].rem  = DivW'(mag) << 32;
      ln_q[0][k].quo  = '0;
    end
  end

  // Restoring division, BitsPerStage quotient bits per stage.
  for (genvar s = 0; s < DivStages; s++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vd_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vd_q[s+1] <= vd_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      div_lane_t l;
      logic [DivW-1:0] trial;
      if (en_i) begin
        sing_q[s+1] <= sing_q[s];
        nd_q[s+1]   <= nd_q[s];
        ad_q[s+1]   <= ad_q[s];
        for (int k = 0; k < 4; k++) begin
          l = ln_q[s][k];
          for (int b = 0; b < BitsPerStage; b++) begin
            trial = DivW'(nd_q[s]) << (DivSteps - 1 - s*BitsPerStage - b);
            if (l.rem >= trial) begin
              l.rem = l.rem - trial;
              l.quo[DivSteps - 1 - s*BitsPerStage - b] = 1'b1;
            end
          end
          ln_q[s+1][k] <= l;
        end
      end
    end
  end

  // Rounding to nearest, sign and saturation of each inverse entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= vd_q[DivStages];
    end
  end

  always_ff @(posedge clk_i) begin
    div_lane_t l;
    logic [DivW-1:0]  half;
    logic [QuotW:0]   q;
    if (en_i) begin
      so_q <= sing_q[DivStages];
      ao_q <= ad_q[DivStages];
      for (int k = 0; k < 4; k++) begin
        l = ln_q[DivStages][k];
        half = DivW'(nd_q[DivStages]) - l.rem;
        q = {1'b0, l.quo} + ((l.rem >= half) ? 65'd1 : 65'd0);
        if (l.zero || sing_q[DivStages]) begin
          io_q[k] <= '0;
        end else if (l.neg) begin
          io_q[k] <= (q >= 65'h8000_0000) ? S32Min : -q[DataW-1:0];
        end else begin
          io_q[k] <= (q > 65'h7FFF_FFFF) ? S32Max : q[DataW-1:0];
        end
      end
    end
  end

  assign valid_o    = vo_q;
  assign singular_o = so_q;
  assign a_o        = ao_q;
  assign inv_o      = io_q;

  // A singular target yields all-zero inverse entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && so_q) |-> (io_q[0] == '0 && io_q[3] == '0))
    else $error("singular target gave nonzero inverse");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(vo_q))
    else $error("inverse pipeline moved while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && v2_q) |=> vd_q[1])
    else $error("divider lost an item");

endmodule

>>> design/tssom_eval.sv
// Pipelined evaluation of T, metric, gradient and Hessian from A and inv(W).
module tssom_eval (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic                 singular_i,
  input  tssom_pkg::q16_t      a_i [4],
  input  tssom_pkg::q16_t      inv_i [4],
  output logic                 valid_o,
  output logic                 singular_o,
  output logic [31:0]          metric_o,
  output tssom_pkg::q16_t      grad_o [4],
  output tssom_pkg::q16_t      hess_o [3]
);
  import tssom_pkg::*;

  // Stage E1: products A*inv and inv*inv.
  logic               v1_q, s1_q;
  logic signed [63:0] pa_q [8];
  logic signed [63:0] ph_q [6];
  q16_t               i1_q [4];
  // Stage E2: T and Hessian.
  logic               v2_q, s2_q;
  q16_t               t_q [4];
  q16_t               h_q [3];
  q16_t               i2_q [4];
  // Stage E3: products of T.
  logic               v3_q, s3_q;
  logic signed [63:0] pt_q [4];
  logic signed [63:0] pg_q [8];
  q16_t               h3_q [3];
  // Stage E4: final sums.
  logic               v4_q, s4_q;
  logic [31:0]        m_q;
  q16_t               g_q [4];
  q16_t               h4_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
    end
  end

  // Products: pa index i*4+j*2+k is a[i][k]*inv[k][j].
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= singular_i;
      i1_q <= inv_i;
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          for (int k = 0; k < 2; k++) begin
            pa_q[i*4+j*2+k] <= 64'(a_i[i*2+k]) * 64'(inv_i[k*2+j]);
          end
        end
      end
      ph_q[0] <= 64'(inv_i[0]) * 64'(inv_i[0]);
      ph_q[1] <= 64'(inv_i[1]) * 64'(inv_i[1]);
      ph_q[2] <= 64'(inv_i[0]) * 64'(inv_i[2]);
      ph_q[3] <= 64'(inv_i[1]) * 64'(inv_i[3]);
      ph_q[4] <= 64'(inv_i[2]) * 64'(inv_i[2]);
      ph_q[5] <= 64'(inv_i[3]) * 64'(inv_i[3]);
    end
  end

  // T entries and Hessian sums.
  always_ff @(posedge clk_i) begin
    logic signed [50:0] s;
    if (en_i) begin
      s2_q <= s1_q;
      i2_q <= i1_q;
      for (int e = 0; e < 4; e++) begin
        s = 51'(rnd16(pa_q[e*2])) + 51'(rnd16(pa_q[e*2+1]));
        if (e == 0 || e == 3) begin
          s = s - 51'(QOne);
        end
        t_q[e] <= sat32(s);
      end
      for (int h = 0; h < 3; h++) begin
        s = (51'(rnd16(ph_q[h*2])) + 51'(rnd16(ph_q[h*2+1]))) <<< 1;
        h_q[h] <= sat32(s);
      end
    end
  end

  // Squares of T and gradient products: pg index i*4+j*2+k is t[i][k]*inv[j][k].
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_q <= s2_q;
      h3_q <= h_q;
      for (int e = 0; e < 4; e++) begin
        pt_q[e] <= 64'(t_q[e]) * 64'(t_q[e]);
      end
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          for (int k = 0; k < 2; k++) begin
            pg_q[i*4+j*2+k] <= 64'(t_q[i*2+k]) * 64'(i2_q[j*2+k]);
          end
        end
      end
    end
  end

  // Metric and gradient sums with saturation; singular forces zeros.
  always_ff @(posedge clk_i) begin
    logic [51:0]        m;
    logic signed [50:0] s;
    if (en_i) begin
      s4_q <= s3_q;
      m = '0;
      for (int e = 0; e < 4; e++) begin
        m = m + 52'(rnd16(pt_q[e]));
      end
      m_q <= s3_q ? '0 : ((m > 52'hFFFF_FFFF) ? 32'hFFFF_FFFF : m[31:0]);
      for (int e = 0; e < 4; e++) begin
        s = (51'(rnd16(pg_q[e*2])) + 51'(rnd16(pg_q[e*2+1]))) <<< 1;
        g_q[e] <= s3_q ? '0 : sat32(s);
      end
      for (int h = 0; h < 3; h++) begin
        h4_q[h] <= s3_q ? '0 : h3_q[h];
      end
    end
  end

  assign valid_o    = v4_q;
  assign singular_o = s4_q;
  assign metric_o   = m_q;
  assign grad_o     = g_q;
  assign hess_o     = h4_q;

  // Singular results carry zero payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && s4_q) |-> (m_q == '0 && g_q[0] == '0 && h4_q[0] == '0))
    else $error("singular result has nonzero payload");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && v3_q) |=> v4_q)
    else $error("evaluation pipeline lost an item");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(m_q))
    else $error("metric changed while stalled");

endmodule

>>> design/target_shape_size_orient_metric_2d.sv
// Top level of the 2x2 target-matrix shape-size-orientation metric pipeline.
// Each beat on the slave side carries A and W and yields one result beat through
// 2 determinant stages, 16 divider stages at 4 quotient bits each, 1 rounding stage,
// 4 evaluation stages and 1 output register. A new beat is taken every cycle while
// the pipeline advances: whenever the output register is empty or being drained.
module target_shape_size_orient_metric_2d (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // a_00, a_01, a_10, a_11, w_00, w_01, w_10, w_11 from the lowest bit up.
  input  logic [255:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // metric, grad_00, grad_01, grad_10, grad_11, hess_00, hess_01, hess_11.
  output logic [255:0] m_axis_tdata_o,
  // singular.
  output logic         m_axis_tuser_o
);
  import tssom_pkg::*;

  logic        en;
  q16_t        a_in [4];
  q16_t        w_in [4];
  logic        iv, isg, ev, esg;
  q16_t        ia [4];
  q16_t        iinv [4];
  logic [31:0] met;
  q16_t        grad [4];
  q16_t        hess [3];
  logic        ov_q, os_q;
  logic [OutTdataW-1:0] od_q;

  // Pipeline advances when the output register can take the last stage's beat.
  assign en = !ov_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      a_in[k] = s_axis_tdata_i[k*DataW +: DataW];
      w_in[k] = s_axis_tdata_i[(k+4)*DataW +: DataW];
    end
  end

  tssom_inv u_inv (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid_i),
    .a_i(a_in), .w_i(w_in), .valid_o(iv), .a_o(ia), .inv_o(iinv), .singular_o(isg)
  );

  tssom_eval u_eval (
    .clk_i, .rst_ni, .en_i(en), .valid_i(iv), .singular_i(isg),
    .a_i(ia), .inv_i(iinv), .valid_o(ev), .singular_o(esg),
    .metric_o(met), .grad_o(grad), .hess_o(hess)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= ev;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      os_q <= esg;
      od_q <= {hess[2], hess[1], hess[0], grad[3], grad[2], grad[1], grad[0], met};
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = od_q;
  assign m_axis_tuser_o  = os_q;

  // A stalled result beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !m_axis_tready_i) |=> (ov_q && $stable(od_q)))
    else $error("result beat changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready does not follow output drain");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && os_q) |-> (od_q == '0))
    else $error("singular beat carries data");

endmodule

>>> sim/tb.sv
// Self-checking testbench for the 2x2 shape-size-orientation metric pipeline.

// Predicts metric, gradient and Hessian beats and compares them with the block's output.
class metric_scoreboard;
  typedef struct {
    logic [255:0] fields;
    logic         singular;
  } metric_res_t;

  metric_res_t pending[$];
  int          errors = 0;

  // Q32.32 to Q16.16, ties toward plus infinity.
  function automatic longint round_q16(longint p);
    longint q;
    q = p + 64'sd32768;
    return q >>> 16;
  endfunction

  function automatic longint mul_q16(longint a, longint b);
    return round_q16(a * b);
  endfunction

  function automatic longint clamp_s32(longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Adjugate entry over the determinant, rounded to nearest with ties away from zero.
  function automatic longint div_q16(longint adj, longint det);
    bit               neg;
    longint unsigned  na;
    longint unsigned  nd;
    longint unsigned  q;
    longint unsigned  r;
    neg = 0;
    if (adj == 0) begin
      return 0;
    end
    if (adj < 0) begin
      na  = longint'(-adj);
      neg = ~neg;
    end else begin
      na = adj;
    end
    if (det < 0) begin
      nd  = 64'd0 - longint'(det);
      neg = ~neg;
    end else begin
      nd = det;
    end
    na = na << 32;
    q  = na / nd;
    r  = na % nd;
    if (r >= nd - r) begin
      q++;
    end
    if (neg) begin
      return (q >= 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
    end
    return (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
  endfunction

  // Works out the expected result beat for one input beat.
  function automatic metric_res_t predict(logic [255:0] in_beat);
    metric_res_t res;
    longint      a [2][2];
    longint      w [2][2];
    longint      inv [2][2];
    longint      t [2][2];
    longint      s;
    longint      det;
    longint      sum_sq;
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        a[i][j] = longint'($signed(in_beat[32*(i*2+j) +: 32]));
        w[i][j] = longint'($signed(in_beat[32*(4+i*2+j) +: 32]));
      end
    end
    res.fields   = '0;
    res.singular = 1'b0;
    det = w[0][0] * w[1][1] - w[0][1] * w[1][0];
    if (det == 0) begin
      res.singular = 1'b1;
      return res;
    end
    inv[0][0] = div_q16(w[1][1], det);
    inv[0][1] = div_q16(-w[0][1], det);
    inv[1][0] = div_q16(-w[1][0], det);
    inv[1][1] = div_q16(w[0][0], det);
    // Deviation from identity and its squared norm.
    sum_sq = 0;
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        s = mul_q16(a[i][0], inv[0][j]) + mul_q16(a[i][1], inv[1][j]);
        if (i == j) begin
          s -= 65536;
        end
        t[i][j] = clamp_s32(s);
        sum_sq += mul_q16(t[i][j], t[i][j]);
      end
    end
    if (sum_sq > 64'sd4294967295) begin
      sum_sq = 64'sd4294967295;
    end
    res.fields[31:0] = sum_sq[31:0];
    // Gradient, row-major.
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        s = clamp_s32(2 * (mul_q16(t[i][0], inv[j][0]) + mul_q16(t[i][1], inv[j][1])));
        res.fields[32*(1+i*2+j) +: 32] = s[31:0];
      end
    end
    // Diagonal Hessian block.
    s = clamp_s32(2 * (mul_q16(inv[0][0], inv[0][0]) + mul_q16(inv[0][1], inv[0][1])));
    res.fields[32*5 +: 32] = s[31:0];
    s = clamp_s32(2 * (mul_q16(inv[0][0], inv[1][0]) + mul_q16(inv[0][1], inv[1][1])));
    res.fields[32*6 +: 32] = s[31:0];
    s = clamp_s32(2 * (mul_q16(inv[1][0], inv[1][0]) + mul_q16(inv[1][1], inv[1][1])));
    res.fields[32*7 +: 32] = s[31:0];
    return res;
  endfunction

  function void note_input(logic [255:0] in_beat);
    pending.push_back(predict(in_beat));
  endfunction

  function void check_result(logic [255:0] fields, logic singular);
    metric_res_t exp_res;
    string       names [8] = '{"metric", "grad_00", "grad_01", "grad_10", "grad_11",
                               "hess_00", "hess_01", "hess_11"};
    if (pending.size() == 0) begin
      $display("%0t: result beat with nothing expected: %h %b", $time, fields, singular);
      errors++;
      return;
    end
    exp_res = pending.pop_front();
    for (int i = 0; i < 8; i++) begin
      if (fields[32*i +: 32] !== exp_res.fields[32*i +: 32]) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, names[i],
                 exp_res.fields[32*i +: 32], fields[32*i +: 32]);
        errors++;
      end
    end
    if (singular !== exp_res.singular) begin
      $display("%0t: singular mismatch, expected %b, got %b", $time,
               exp_res.singular, singular);
      errors++;
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRandom = 1280;
  localparam int QuietFrom = 1150;
  localparam int HoldItem  = 400;
  localparam int DrainItem = 800;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [255:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [255:0] m_axis_tdata_o;
  logic         m_axis_tuser_o;

  metric_scoreboard sb = new();
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  target_shape_size_orient_metric_2d dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Note accepted input beats and check accepted result beats.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      sb.note_input(s_axis_tdata_i);
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
    end
  end

  function automatic logic [255:0] pack_mats(logic [31:0] a00, logic [31:0] a01,
                                             logic [31:0] a10, logic [31:0] a11,
                                             logic [31:0] w00, logic [31:0] w01,
                                             logic [31:0] w10, logic [31:0] w11);
    return {w11, w10, w01, w00, a11, a10, a01, a00};
  endfunction

  // Signed value of roughly plus or minus 2^(bits-1) raw units.
  function automatic logic [31:0] rand_span(int bits);
    return 32'($signed($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1)));
  endfunction

  // Random beat: small or full-range values, with near-identity, singular and tiny targets mixed in.
  function automatic logic [255:0] rand_mats();
    logic [31:0] m [8];
    int          k;
    int          kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 8; i++) begin
      m[i] = (kind < 4) ? rand_span(20) : $urandom();
    end
    case (kind)
      0, 1: begin
        // Target near identity.
        m[4] = 32'h0001_0000 + rand_span(15);
        m[7] = 32'h0001_0000 + rand_span(15);
      end
      6: begin
        // Second target row a multiple of the first.
        k = $signed($urandom_range(0, 6)) - 3;
        m[4] = rand_span(24);
        m[5] = rand_span(24);
        m[6] = 32'($signed(m[4]) * k);
        m[7] = 32'($signed(m[5]) * k);
      end
      7: begin
        // Tiny target determinant drives the inverse into saturation.
        for (int i = 4; i < 8; i++) begin
          m[i] = rand_span(3);
        end
      end
      8: begin
        for (int i = 4; i < 8; i++) begin
          m[i] = rand_span(22);
        end
      end
      default: begin
      end
    endcase
    return pack_mats(m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7]);
  endfunction

  // Offer one beat and hold it until the block takes it.
  task automatic send_beat(logic [255:0] beat);
    s_axis_tdata_i  <= beat;
    s_axis_tvalid_i <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready_o);
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  // Receiver: random stall bursts, one long hold on request, none at the end.
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (quiet || $urandom_range(0, 1) == 0) begin
        m_axis_tready_i <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
    end
  end

  initial begin
    logic [255:0] directed [$];
    int           waited;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // All zero: singular target.
    directed.push_back('0);
    // Identity for both: zero metric.
    directed.push_back(pack_mats(32'h10000, 0, 0, 32'h10000, 32'h10000, 0, 0, 32'h10000));
    // A equal to W, non-trivial.
    directed.push_back(pack_mats(32'h20000, 32'h8000, 32'hFFFF0000, 32'h30000,
                                 32'h20000, 32'h8000, 32'hFFFF0000, 32'h30000));
    // Negative determinant.
    directed.push_back(pack_mats(32'h10000, 32'h20000, 32'h30000, 32'h40000,
                                 0, 32'h10000, 32'h10000, 0));
    // Extremes of every field.
    directed.push_back({8{32'h7FFFFFFF}});
    directed.push_back({8{32'h80000000}});
    directed.push_back(pack_mats(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                                 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF));
    directed.push_back(pack_mats(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                                 32'h80000000, 0, 0, 32'h80000000));
    // Smallest possible target: inverse saturates, later stages use saturated values.
    directed.push_back(pack_mats(32'h10000, 0, 0, 32'h10000, 1, 0, 0, 1));
    directed.push_back(pack_mats(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                 1, 0, 0, 32'hFFFFFFFF));
    // Rounding ties in the inverse and the products.
    directed.push_back(pack_mats(1, 1, 32'hFFFFFFFF, 1, 32'h20000, 0, 0, 32'h20000));
    directed.push_back(pack_mats(32'h8000, 32'hFFFF8000, 1, 32'hFFFFFFFF,
                                 32'h30000, 0, 0, 32'h30000));
    // Singular with proportional rows and with a zero column.
    directed.push_back(pack_mats(32'h10000, 0, 0, 32'h10000,
                                 32'h10000, 32'h20000, 32'h20000, 32'h40000));
    directed.push_back(pack_mats(32'h7FFFFFFF, 1, 2, 3, 0, 32'h7FFFFFFF, 0, 32'h80000000));
    // Huge A with a small target: metric saturates.
    directed.push_back(pack_mats(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                                 32'h100, 0, 0, 32'h100));
    // Zero A: T is minus identity.
    directed.push_back(pack_mats(0, 0, 0, 0, 32'h10000, 32'h10000, 0, 32'h10000));
    foreach (directed[i]) begin
      sender_gap();
      send_beat(directed[i]);
    end

    for (int n = 0; n < NumRandom; n++) begin
      if (n == HoldItem) begin
        hold_req = 1'b1;
      end
      if (n == DrainItem) begin
        // Pause until every outstanding result has come back.
        s_axis_tvalid_i <= 1'b0;
        @(posedge clk_i);
        while (sb.pending.size() != 0) begin
          @(posedge clk_i);
        end
      end
      if (n == QuietFrom) begin
        quiet = 1'b1;
      end
      if (n != DrainItem) begin
        sender_gap();
      end
      send_beat(rand_mats());
    end
    s_axis_tvalid_i <= 1'b0;

    waited = 0;
    while (sb.pending.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("target_shape_size_orient_metric_2d test passed");
    end else begin
      if (sb.pending.size() != 0) begin
        $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
      end
      $display("target_shape_size_orient_metric_2d test failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("target_shape_size_orient_metric_2d test failed");
    $finish;
  end
endmodule
